// File: rtl/dpc_pkg.sv
// Shared constants, mode codes and compare helpers for the debounced presence counter.
// No dependencies.
package dpc_pkg;

	localparam int TIME_W = 63;
	localparam int CFG_W  = 32;
	localparam int MODE_W = 3;
	localparam int REG_IDX_W = 2;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [CFG_W-1:0]  cfg_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// Machine modes
	localparam mode_t MODE_WAIT_CLEAR       = 3'd0;
	localparam mode_t MODE_FREE             = 3'd1;
	localparam mode_t MODE_CONFIRM_PRESENCE = 3'd2;
	localparam mode_t MODE_PRESENT          = 3'd3;
	localparam mode_t MODE_CONFIRM_RELEASE  = 3'd4;

	// Register indexes
	localparam reg_idx_t REG_MAX_GAP  = 2'd0;
	localparam reg_idx_t REG_RELEASE  = 2'd1;
	localparam reg_idx_t REG_PRESENCE = 2'd2;
	localparam reg_idx_t REG_BLOCKED  = 2'd3;

	// Reset values of the registers
	localparam cfg_t RST_MAX_GAP  = 32'd1000000;
	localparam cfg_t RST_RELEASE  = 32'd300000;
	localparam cfg_t RST_PRESENCE = 32'd300000;
	localparam cfg_t RST_BLOCKED  = 32'd10000000;

	// Wide duration against a 32-bit threshold: duration >= threshold
	function automatic logic dur_ge(input time_t dur, input cfg_t thr);
		dur_ge = (dur[TIME_W-1:CFG_W] != '0) || (dur[CFG_W-1:0] >= thr);
	endfunction

	// Wide duration against a 32-bit threshold: duration > threshold
	function automatic logic dur_gt(input time_t dur, input cfg_t thr);
		dur_gt = (dur[TIME_W-1:CFG_W] != '0) || (dur[CFG_W-1:0] > thr);
	endfunction

endpackage

// File: rtl/debounced_presence_counter.sv
// Debounced presence counter: timestamped samples in, one flag word out per sample.
// Depends on dpc_pkg.
// Path from input handshake to earliest output handshake: input register, then result register.
// Throughput: one word per cycle while out_ready stays high; the machine state updates as
// the word leaves the input register, so consecutive words see each other's effect.
// Reset (arst_n low, asynchronous): machine in wait-for-clear, all times zero,
// registers at their defaults, both pipeline stages empty.
module debounced_presence_counter (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  dpc_pkg::reg_idx_t     cfg_index,
	input  dpc_pkg::cfg_t         cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic                  present,
	input  logic                  activity,
	input  dpc_pkg::time_t        time_us,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  resync_flag,
	output logic                  ready_flag,
	output logic                  count_flag,
	output logic                  cleared_flag,
	output logic                  blocked_flag
);
	import dpc_pkg::*;

	// configuration registers
	cfg_t max_gap_q, release_q, presence_q, blocked_time_q;

	// machine state
	mode_t mode_q;
	time_t stable_since_q, occ_since_q, last_time_q;
	logic  occ_valid_q, last_pres_q, is_blocked_q;

	// input stage
	logic  valid_s1, cmd_s1, pres_s1, act_s1;
	time_t time_s1;

	// result stage
	logic  valid_s2, resync_s2, ready_s2, count_s2, cleared_s2, blocked_s2;

	logic advance;
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	logic proc;
	assign proc = valid_s1 && advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q      <= RST_MAX_GAP;
			release_q      <= RST_RELEASE;
			presence_q     <= RST_PRESENCE;
			blocked_time_q <= RST_BLOCKED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_GAP:  max_gap_q      <= cfg_data;
				REG_RELEASE:  release_q      <= cfg_data;
				REG_PRESENCE: presence_q     <= cfg_data;
				REG_BLOCKED:  blocked_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= command;
			pres_s1 <= present;
			act_s1  <= activity;
			time_s1 <= time_us;
		end
	end

	// next-state logic
	mode_t mode_n;
	time_t stable_since_n, occ_since_n, last_time_n;
	logic  occ_valid_n, last_pres_n, is_blocked_n;
	logic  resync_n, ready_n, count_n, cleared_n, blocked_n;
	time_t gap, stable, occ_dur;
	logic  restart, stable_rel, stable_pres;
	mode_t mode_sw;
	logic  occ_v_sw;
	time_t occ_s_sw;

	always_comb begin
		gap     = time_s1 - last_time_q;
		restart = cmd_s1 || (time_s1 < last_time_q) || dur_gt(gap, max_gap_q);

		// stability timer restarts on activity or a presence change
		stable      = (act_s1 || (pres_s1 != last_pres_q)) ? '0 : time_s1 - stable_since_q;
		stable_rel  = dur_ge(stable, release_q);
		stable_pres = dur_ge(stable, presence_q);

		mode_sw  = mode_q;
		occ_v_sw = occ_valid_q;
		occ_s_sw = occ_since_q;
		ready_n  = 1'b0;
		count_n  = 1'b0;
		unique case (mode_q)
			MODE_WAIT_CLEAR: begin
				if (pres_s1 && !occ_valid_q) begin
					occ_v_sw = 1'b1;
					occ_s_sw = time_s1;
				end
				if (!pres_s1 && stable_rel) begin
					mode_sw = MODE_FREE;
					ready_n = 1'b1;
				end
			end
			MODE_FREE: begin
				if (pres_s1) begin
					mode_sw  = MODE_CONFIRM_PRESENCE;
					occ_v_sw = 1'b1;
					occ_s_sw = time_s1;
				end
			end
			MODE_CONFIRM_PRESENCE: begin
				if (!pres_s1) begin
					mode_sw  = MODE_FREE;
					occ_v_sw = 1'b0;
					occ_s_sw = '0;
				end else if (stable_pres) begin
					mode_sw = MODE_PRESENT;
				end
			end
			MODE_PRESENT: begin
				if (!pres_s1) mode_sw = MODE_CONFIRM_RELEASE;
			end
			MODE_CONFIRM_RELEASE: begin
				if (pres_s1) begin
					mode_sw = MODE_PRESENT;
				end else if (stable_rel) begin
					mode_sw = MODE_FREE;
					count_n = 1'b1;
				end
			end
			default: ;
		endcase

		// blocked / free bookkeeping
		occ_dur      = time_s1 - occ_s_sw;
		occ_valid_n  = occ_v_sw;
		occ_since_n  = occ_s_sw;
		is_blocked_n = is_blocked_q;
		cleared_n    = 1'b0;
		blocked_n    = 1'b0;
		if (mode_sw == MODE_FREE) begin
			cleared_n    = is_blocked_q;
			is_blocked_n = 1'b0;
			occ_valid_n  = 1'b0;
			occ_since_n  = '0;
		end else if (!is_blocked_q && occ_v_sw && (time_s1 >= occ_s_sw) &&
		             dur_ge(occ_dur, blocked_time_q)) begin
			is_blocked_n = 1'b1;
			blocked_n    = 1'b1;
		end

		mode_n         = mode_sw;
		stable_since_n = (act_s1 || (pres_s1 != last_pres_q)) ? time_s1 : stable_since_q;
		last_time_n    = time_s1;
		last_pres_n    = pres_s1;
		resync_n       = 1'b0;

		// restart command, backward time or long gap
		if (restart) begin
			mode_n         = MODE_WAIT_CLEAR;
			stable_since_n = time_s1;
			occ_valid_n    = pres_s1;
			occ_since_n    = pres_s1 ? time_s1 : '0;
			last_pres_n    = pres_s1;
			is_blocked_n   = 1'b0;
			ready_n        = 1'b0;
			count_n        = 1'b0;
			cleared_n      = 1'b0;
			blocked_n      = 1'b0;
			resync_n       = !cmd_s1;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_WAIT_CLEAR;
			stable_since_q <= '0;
			occ_valid_q    <= 1'b0;
			occ_since_q    <= '0;
			last_time_q    <= '0;
			last_pres_q    <= 1'b0;
			is_blocked_q   <= 1'b0;
		end else if (proc) begin
			mode_q         <= mode_n;
			stable_since_q <= stable_since_n;
			occ_valid_q    <= occ_valid_n;
			occ_since_q    <= occ_since_n;
			last_time_q    <= last_time_n;
			last_pres_q    <= last_pres_n;
			is_blocked_q   <= is_blocked_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			resync_s2  <= resync_n;
			ready_s2   <= ready_n;
			count_s2   <= count_n;
			cleared_s2 <= cleared_n;
			blocked_s2 <= blocked_n;
		end
	end

	assign out_valid    = valid_s2;
	assign resync_flag  = resync_s2;
	assign ready_flag   = ready_s2;
	assign count_flag   = count_s2;
	assign cleared_flag = cleared_s2;
	assign blocked_flag = blocked_s2;

endmodule
